/* src/lspg_pkg.sv */
package lspg_pkg;

	localparam int IdxW = 6;
	localparam int ColW = 8;

	localparam logic [2:0] MODE_VIOLET = 3'd0;
	localparam logic [2:0] MODE_AMBER  = 3'd1;
	localparam logic [2:0] MODE_PURPLE = 3'd2;
	localparam logic [2:0] MODE_SPRING = 3'd3;
	localparam logic [2:0] MODE_CHASE  = 3'd4;
	localparam logic [2:0] MODE_LINEAR = 3'd5;
	localparam logic [2:0] MODE_SINE   = 3'd6;
	localparam logic [2:0] MODE_OFF    = 3'd7;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_COLOR  = 2'd1;
	localparam logic [1:0] REG_TAIL   = 2'd2;
	localparam logic [1:0] REG_PERIOD = 2'd3;

	localparam logic [23:0] COL_VIOLET = 24'h9400D3;
	localparam logic [23:0] COL_AMBER  = 24'hFFBE00;
	localparam logic [23:0] COL_PURPLE = 24'h800080;
	localparam logic [23:0] COL_SPRING = 24'h00FA9A;

	typedef logic [2:0] div_op_t;

	localparam div_op_t DIV_PHASE = 3'd0;
	localparam div_op_t DIV_LIN   = 3'd1;
	localparam div_op_t DIV_K     = 3'd2;
	localparam div_op_t DIV_COS   = 3'd3;
	localparam div_op_t DIV_STEP  = 3'd4;
	localparam div_op_t DIV_INIT  = 3'd5;

	typedef struct packed {
		logic    div_start;
		div_op_t div_op;
		logic    pix_clr;
		logic    pix_adv;
		logic    head_adv;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_pix;
		logic out_free;
	} sts_t;

endpackage

/* src/lspg_div.sv */
module lspg_div #(
	parameter int NW = 24,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CntW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     shifted;
	logic [DW:0]     diff;
	logic            ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CntW'(NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CntW'(1);
			done_q <= cnt_q == CntW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* src/lspg_dp.sv */
module lspg_dp #(
	parameter int STRIP_LENGTH    = 60,
	parameter int COS_TABLE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lspg_pkg::cmd_t             cmd,
	output lspg_pkg::sts_t             sts,
	input  logic [2:0]                 mode,
	input  logic [23:0]                color,
	input  logic [5:0]                 tail,
	input  logic [15:0]                period,
	input  logic [15:0]                elapsed,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [lspg_pkg::IdxW-1:0]  pixel_index,
	output logic [lspg_pkg::ColW-1:0]  red,
	output logic [lspg_pkg::ColW-1:0]  green,
	output logic [lspg_pkg::ColW-1:0]  blue,
	output logic                       last_pixel
);

	localparam int CosN  = COS_TABLE_DEPTH - 1;
	localparam int CosW  = $clog2(COS_TABLE_DEPTH);
	localparam int SqW   = 2 * CosW;
	localparam int NumA  = 16 + CosW;
	localparam int NumB  = SqW + 9;
	localparam int NumAB = (NumA > NumB) ? NumA : NumB;
	localparam int NumW  = (NumAB > 24) ? NumAB : 24;
	localparam int DenW  = (SqW + 1 > 16) ? SqW + 1 : 16;
	localparam logic [CosW-1:0] NVal = CosW'(CosN);
	localparam logic [SqW-1:0]  NSq  = SqW'(CosN * CosN);
	localparam logic [lspg_pkg::IdxW-1:0] LastIdx = lspg_pkg::IdxW'(STRIP_LENGTH - 1);

	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [9:0] f);
		logic [17:0] p;
		p = c * f;
		return (p[17:16] != 2'b00) ? 8'hFF : p[15:8];
	endfunction

	logic [15:0]               phase_q;
	logic [5:0]                head_q;
	logic [lspg_pkg::IdxW-1:0] pix_q;
	logic [CosW-1:0]           k_q;
	logic [SqW-1:0]            aa_q;
	logic [9:0]                f_q;
	logic [9:0]                cq_q;
	logic [5:0]                cr_q;
	logic [8:0]                sq_q;
	logic [5:0]                sr_q;
	lspg_pkg::div_op_t         op_q;

	logic            div_busy;
	logic            div_done;
	logic [NumW-1:0] div_quo;
	logic [DenW-1:0] div_rem;
	logic [NumW-1:0] div_num;
	logic [DenW-1:0] div_den;

	logic [15:0]        p_rest;
	logic [15:0]        lp;
	logic [15+CosW:0]   kprod;
	logic               k_low;
	logic [CosW-1:0]    a_val;
	logic [DenW-1:0]    cos_den;
	logic [SqW-1:0]     cos_num;
	logic [9:0]         cos_q;
	logic [9:0]         cos_f;
	logic [6:0]         tail1;
	logic [6:0]         head7;
	logic [6:0]         pix7;
	logic [6:0]         nxt7;
	logic [6:0]         d_cur;
	logic [6:0]         d_nxt;
	logic [6:0]         dc_cur;
	logic [6:0]         dc_nxt;
	logic [6:0]         dc0;
	logic [6:0]         r_add;
	logic [6:0]         r_sub;
	logic               wrap;
	logic               borrow;
	logic [5:0]         r_up;
	logic [5:0]         r_dn;
	logic [9:0]         q_up;
	logic [9:0]         q_dn;
	logic [23:0]        rgb;

	logic                      out_valid_q;
	logic [lspg_pkg::IdxW-1:0] out_idx_q;
	logic [7:0]                out_red_q;
	logic [7:0]                out_green_q;
	logic [7:0]                out_blue_q;
	logic                      out_last_q;

	assign p_rest = period - phase_q;
	assign lp     = (phase_q < p_rest) ? phase_q : p_rest;
	assign kprod  = lp * NVal;

	assign k_low   = {k_q, 1'b0} <= {1'b0, NVal};
	assign a_val   = k_low ? k_q : NVal - k_q;
	assign cos_den = DenW'(NSq) + DenW'(aa_q);
	assign cos_num = SqW'({2'b00, NSq} - {aa_q, 2'b00});
	assign cos_q   = div_quo[9:0];
	assign cos_f   = k_low ? ((10'd256 - cos_q) >> 1) : ((10'd256 + cos_q) >> 1);

	assign tail1 = {1'b0, tail} + 7'd1;
	assign head7 = {1'b0, head_q};
	assign pix7  = {1'b0, pix_q};
	assign nxt7  = pix7 + 7'd1;
	assign d_cur = (head7 > pix7) ? head7 - pix7 : pix7 - head7;
	assign d_nxt = (head7 > nxt7) ? head7 - nxt7 : nxt7 - head7;
	assign dc_cur = (d_cur < tail1) ? d_cur : tail1;
	assign dc_nxt = (d_nxt < tail1) ? d_nxt : tail1;
	assign dc0    = (head7 < tail1) ? head7 : tail1;

	assign r_add  = {1'b0, cr_q} + {1'b0, sr_q};
	assign wrap   = r_add >= {1'b0, tail};
	assign r_up   = wrap ? 6'(r_add - {1'b0, tail}) : r_add[5:0];
	assign q_up   = cq_q + 10'(sq_q) + 10'(wrap);
	assign r_sub  = {1'b0, cr_q} - {1'b0, sr_q};
	assign borrow = cr_q < sr_q;
	assign r_dn   = borrow ? 6'(r_sub + {1'b0, tail}) : r_sub[5:0];
	assign q_dn   = cq_q - 10'(sq_q) - 10'(borrow);

	always_comb begin
		div_num = '0;
		div_den = DenW'(period);
		unique case (cmd.div_op)
			lspg_pkg::DIV_PHASE: div_num = NumW'({1'b0, phase_q} + {1'b0, elapsed});
			lspg_pkg::DIV_LIN:   div_num = NumW'({lp, 9'd0});
			lspg_pkg::DIV_K:     div_num = NumW'({kprod, 1'b0}) + NumW'(period[15:1]);
			lspg_pkg::DIV_COS: begin
				div_num = NumW'({cos_num, 8'd0}) + NumW'(cos_den[DenW-1:1]);
				div_den = cos_den;
			end
			lspg_pkg::DIV_STEP: begin
				div_num = NumW'(9'd256);
				div_den = DenW'(tail);
			end
			lspg_pkg::DIV_INIT: begin
				div_num = NumW'({tail1 - dc0, 8'd0});
				div_den = DenW'(tail);
			end
			default: div_num = '0;
		endcase
	end

	lspg_div #(
		.NW(NumW),
		.DW(DenW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(div_num),
		.divisor(div_den),
		.busy(div_busy),
		.done(div_done),
		.quo(div_quo),
		.rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			head_q  <= '0;
		end else begin
			if (div_done && op_q == lspg_pkg::DIV_PHASE) begin
				phase_q <= div_rem[15:0];
			end
			if (cmd.head_adv) begin
				head_q <= (head_q == LastIdx) ? '0 : head_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		aa_q <= a_val * a_val;
		if (cmd.div_start) begin
			op_q <= cmd.div_op;
		end
		if (cmd.pix_clr) begin
			pix_q <= '0;
		end else if (cmd.pix_adv) begin
			pix_q <= pix_q + 1'b1;
		end
		if (div_done) begin
			unique case (op_q)
				lspg_pkg::DIV_LIN: f_q <= div_quo[9:0];
				lspg_pkg::DIV_K:   k_q <= div_quo[CosW-1:0];
				lspg_pkg::DIV_COS: f_q <= cos_f;
				lspg_pkg::DIV_STEP: begin
					sq_q <= div_quo[8:0];
					sr_q <= div_rem[5:0];
				end
				lspg_pkg::DIV_INIT: begin
					cq_q <= div_quo[9:0];
					cr_q <= div_rem[5:0];
				end
				default: f_q <= f_q;
			endcase
		end else if (cmd.pix_adv && dc_nxt < dc_cur) begin
			cq_q <= q_up;
			cr_q <= r_up;
		end else if (cmd.pix_adv && dc_nxt > dc_cur) begin
			cq_q <= q_dn;
			cr_q <= r_dn;
		end
	end

	always_comb begin
		unique case (mode)
			lspg_pkg::MODE_VIOLET: rgb = lspg_pkg::COL_VIOLET;
			lspg_pkg::MODE_AMBER:  rgb = lspg_pkg::COL_AMBER;
			lspg_pkg::MODE_PURPLE: rgb = lspg_pkg::COL_PURPLE;
			lspg_pkg::MODE_SPRING: rgb = lspg_pkg::COL_SPRING;
			lspg_pkg::MODE_CHASE: begin
				rgb = {scale_ch(color[23:16], cq_q), scale_ch(color[15:8], cq_q),
					scale_ch(color[7:0], cq_q)};
			end
			lspg_pkg::MODE_LINEAR, lspg_pkg::MODE_SINE: begin
				rgb = {scale_ch(color[23:16], f_q), scale_ch(color[15:8], f_q),
					scale_ch(color[7:0], f_q)};
			end
			default: rgb = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pix_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_adv) begin
			out_idx_q   <= pix_q;
			out_red_q   <= rgb[23:16];
			out_green_q <= rgb[15:8];
			out_blue_q  <= rgb[7:0];
			out_last_q  <= pix_q == LastIdx;
		end
	end

	assign sts.div_done = div_done;
	assign sts.last_pix = pix_q == LastIdx;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign pixel_index = out_idx_q;
	assign red         = out_red_q;
	assign green       = out_green_q;
	assign blue        = out_blue_q;
	assign last_pixel  = out_last_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && op_q == lspg_pkg::DIV_PHASE) |=> phase_q < period)
		else $error("phase not below period");

	a_chase_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pix_adv && mode == lspg_pkg::MODE_CHASE) |-> cr_q < tail)
		else $error("chase remainder out of range");

	a_cos_q: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && op_q == lspg_pkg::DIV_COS) |-> div_quo <= NumW'(256))
		else $error("cosine quotient above one");

endmodule

/* src/lspg_ctrl.sv */
module lspg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     mode,
	input  logic           in_valid,
	output logic           in_ready,
	input  lspg_pkg::sts_t sts,
	output lspg_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_PH_WAIT   = 4'd1;
	localparam logic [3:0] S_LIN_GO    = 4'd2;
	localparam logic [3:0] S_LIN_WAIT  = 4'd3;
	localparam logic [3:0] S_K_GO      = 4'd4;
	localparam logic [3:0] S_K_WAIT    = 4'd5;
	localparam logic [3:0] S_SQ        = 4'd6;
	localparam logic [3:0] S_COS_GO    = 4'd7;
	localparam logic [3:0] S_COS_WAIT  = 4'd8;
	localparam logic [3:0] S_STEP_GO   = 4'd9;
	localparam logic [3:0] S_STEP_WAIT = 4'd10;
	localparam logic [3:0] S_INIT_GO   = 4'd11;
	localparam logic [3:0] S_INIT_WAIT = 4'd12;
	localparam logic [3:0] S_EMIT      = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = lspg_pkg::DIV_PHASE;
					cmd.pix_clr   = 1'b1;
					state_nxt     = S_PH_WAIT;
				end
			end
			S_PH_WAIT: begin
				if (sts.div_done) begin
					priority if (mode == lspg_pkg::MODE_CHASE) begin
						state_nxt = S_STEP_GO;
					end else if (mode == lspg_pkg::MODE_LINEAR) begin
						state_nxt = S_LIN_GO;
					end else if (mode == lspg_pkg::MODE_SINE) begin
						state_nxt = S_K_GO;
					end else begin
						state_nxt = S_EMIT;
					end
				end
			end
			S_LIN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lspg_pkg::DIV_LIN;
				state_nxt     = S_LIN_WAIT;
			end
			S_LIN_WAIT: begin
				if (sts.div_done) begin
					state_nxt = S_EMIT;
				end
			end
			S_K_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lspg_pkg::DIV_K;
				state_nxt     = S_K_WAIT;
			end
			S_K_WAIT: begin
				if (sts.div_done) begin
					state_nxt = S_SQ;
				end
			end
			S_SQ: state_nxt = S_COS_GO;
			S_COS_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lspg_pkg::DIV_COS;
				state_nxt     = S_COS_WAIT;
			end
			S_COS_WAIT: begin
				if (sts.div_done) begin
					state_nxt = S_EMIT;
				end
			end
			S_STEP_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lspg_pkg::DIV_STEP;
				state_nxt     = S_STEP_WAIT;
			end
			S_STEP_WAIT: begin
				if (sts.div_done) begin
					state_nxt = S_INIT_GO;
				end
			end
			S_INIT_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = lspg_pkg::DIV_INIT;
				state_nxt     = S_INIT_WAIT;
			end
			S_INIT_WAIT: begin
				if (sts.div_done) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.pix_adv = 1'b1;
					if (sts.last_pix) begin
						cmd.head_adv = mode == lspg_pkg::MODE_CHASE;
						state_nxt    = S_IDLE;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* src/led_strip_pattern_generator_core.sv */
// Frame-tick driven pattern generator for an LED strip: each accepted item carries the timer
// ticks since the previous tick and yields STRIP_LENGTH pixel items in order, the last one
// flagged. Every division goes through one shared bit-serial divider of W bits (W is 25 with the
// default cosine depth). A frame costs one division for the phase update, one more for the linear
// pulse, two more for the chase or the sine pulse, and then one cycle per pixel while the output
// side keeps up. A new item is taken once the last pixel of the frame has entered the output
// register.
module led_strip_pattern_generator_core #(
	parameter int STRIP_LENGTH    = 60,
	parameter int COS_TABLE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [15:0]                elapsed,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lspg_pkg::IdxW-1:0]  pixel_index,
	output logic [lspg_pkg::ColW-1:0]  red,
	output logic [lspg_pkg::ColW-1:0]  green,
	output logic [lspg_pkg::ColW-1:0]  blue,
	output logic                       last_pixel
);

	logic [2:0]     mode_q;
	logic [23:0]    color_q;
	logic [5:0]     tail_q;
	logic [15:0]    period_q;
	logic [5:0]     tail_eff;
	logic [15:0]    period_eff;
	lspg_pkg::cmd_t cmd;
	lspg_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lspg_pkg::MODE_OFF;
			color_q  <= 24'h9400D3;
			tail_q   <= 6'd10;
			period_q <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				lspg_pkg::REG_MODE:   mode_q   <= pwdata[2:0];
				lspg_pkg::REG_COLOR:  color_q  <= pwdata[23:0];
				lspg_pkg::REG_TAIL:   tail_q   <= pwdata[5:0];
				lspg_pkg::REG_PERIOD: period_q <= pwdata[15:0];
				default: mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lspg_pkg::REG_MODE:   prdata = {29'd0, mode_q};
			lspg_pkg::REG_COLOR:  prdata = {8'd0, color_q};
			lspg_pkg::REG_TAIL:   prdata = {26'd0, tail_q};
			lspg_pkg::REG_PERIOD: prdata = {16'd0, period_q};
			default: prdata = '0;
		endcase
	end

	assign pready     = 1'b1;
	assign tail_eff   = (tail_q == 6'd0) ? 6'd1 : tail_q;
	assign period_eff = (period_q < 16'd2) ? 16'd2 : period_q;

	lspg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.mode(mode_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	lspg_dp #(
		.STRIP_LENGTH(STRIP_LENGTH),
		.COS_TABLE_DEPTH(COS_TABLE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.mode(mode_q),
		.color(color_q),
		.tail(tail_eff),
		.period(period_eff),
		.elapsed(elapsed),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.last_pixel(last_pixel)
	);

endmodule
